// ===== hdl/fwd_pkg.sv =====
// Shared types, sizes and helpers for the queue with delete by value.
package fwd_pkg;

  localparam int DEPTH  = 16;
  localparam int DATA_W = 32;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int VAL_W  = 32;
  localparam int LEN_W  = 5;
  localparam int REQ_W  = 2;

  typedef enum logic [REQ_W-1:0] {
    REQ_ENQ = 2'd0,
    REQ_DEQ = 2'd1,
    REQ_DEL = 2'd2,
    REQ_LEN = 2'd3
  } req_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DEQ,
    ST_SRCH,
    ST_SHIFT,
    ST_RESP
  } state_t;

  typedef struct packed {
    logic             status;
    logic [VAL_W-1:0] value;
    logic [LEN_W-1:0] length;
  } fwd_res_t;

  localparam logic ST_OK  = 1'b0;
  localparam logic ST_REF = 1'b1;

  function automatic logic [ADDR_W-1:0] ptr_inc(input logic [ADDR_W-1:0] p);
    return (p == ADDR_W'(DEPTH - 1)) ? '0 : ADDR_W'(p + 1'b1);
  endfunction

  function automatic logic [ADDR_W-1:0] ptr_dec(input logic [ADDR_W-1:0] p);
    return (p == '0) ? ADDR_W'(DEPTH - 1) : ADDR_W'(p - 1'b1);
  endfunction

endpackage

// ===== hdl/fwd_core.sv =====
// Queue store, pointers and the sequencer that searches and compacts on delete.
module fwd_core (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [fwd_pkg::REQ_W-1:0]   req_type,
  input  logic [fwd_pkg::VAL_W-1:0]   value,
  input  logic                        room,
  output logic                        res_valid,
  output fwd_pkg::fwd_res_t           res
);
  import fwd_pkg::*;

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rd_data;

  state_t            state, state_next;
  logic [CNT_W-1:0]  cnt, cnt_next;
  logic [ADDR_W-1:0] head, head_next;
  logic [ADDR_W-1:0] tail, tail_next;
  logic [ADDR_W-1:0] rd_ptr, rd_ptr_next;
  logic [ADDR_W-1:0] wr_ptr, wr_ptr_next;
  logic [CNT_W-1:0]  pos, pos_next;
  logic [DATA_W-1:0] tag, tag_next;
  logic              res_status, res_status_next;
  logic [DATA_W-1:0] res_data, res_data_next;

  logic              accept;
  logic [DATA_W-1:0] in_tag;
  logic              last;
  logic              hit;
  logic              we;
  logic [ADDR_W-1:0] wr_addr;
  logic [DATA_W-1:0] wr_data;
  logic [ADDR_W-1:0] rd_addr;

  assign in_tag = DATA_W'(value);
  assign accept = in_valid && !in_stall;
  assign last   = (CNT_W'(pos + 1'b1) == cnt);
  assign hit    = (rd_data == tag);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          case (req_t'(req_type))
            REQ_DEQ: if (cnt != '0) state_next = ST_DEQ;
            REQ_DEL: if (in_tag != '0 && cnt != '0) state_next = ST_SRCH;
            default: state_next = ST_IDLE;
          endcase
        end
      end
      ST_DEQ:   state_next = ST_RESP;
      ST_SRCH: begin
        if (last) state_next = ST_RESP;
        else if (hit) state_next = ST_SHIFT;
      end
      ST_SHIFT: if (last) state_next = ST_RESP;
      ST_RESP:  if (room) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // outputs and datapath
  always_comb begin
    in_stall        = !(state == ST_IDLE) || !room;
    res_valid       = 1'b0;
    res.status      = res_status;
    res.value       = VAL_W'(res_data);
    res.length      = LEN_W'(cnt);
    cnt_next        = cnt;
    head_next       = head;
    tail_next       = tail;
    rd_ptr_next     = rd_ptr;
    wr_ptr_next     = wr_ptr;
    pos_next        = pos;
    tag_next        = tag;
    res_status_next = res_status;
    res_data_next   = res_data;
    we              = 1'b0;
    wr_addr         = tail;
    wr_data         = in_tag;
    rd_addr         = rd_ptr;
    case (state)
      ST_IDLE: begin
        rd_addr = head;
        if (accept) begin
          res.status = ST_OK;
          res.value  = '0;
          case (req_t'(req_type))
            REQ_ENQ: begin
              res_valid = 1'b1;
              if (in_tag == '0 || cnt == CNT_W'(DEPTH)) begin
                res.status = ST_REF;
              end else begin
                we         = 1'b1;
                tail_next  = ptr_inc(tail);
                cnt_next   = CNT_W'(cnt + 1'b1);
                res.length = LEN_W'(CNT_W'(cnt + 1'b1));
              end
            end
            REQ_DEQ: begin
              if (cnt == '0) begin
                res_valid  = 1'b1;
                res.status = ST_REF;
              end
            end
            REQ_DEL: begin
              if (in_tag == '0 || cnt == '0) begin
                res_valid = 1'b1;
              end else begin
                tag_next    = in_tag;
                rd_ptr_next = head;
                pos_next    = '0;
              end
            end
            default: res_valid = 1'b1;
          endcase
          res_status_next = ST_OK;
          res_data_next   = '0;
        end
      end
      ST_DEQ: begin
        res_data_next = rd_data;
        head_next     = ptr_inc(head);
        cnt_next      = CNT_W'(cnt - 1'b1);
      end
      ST_SRCH: begin
        if (hit && last) begin
          cnt_next  = CNT_W'(cnt - 1'b1);
          tail_next = ptr_dec(tail);
        end else if (!last) begin
          if (hit) wr_ptr_next = rd_ptr;
          rd_addr     = ptr_inc(rd_ptr);
          rd_ptr_next = ptr_inc(rd_ptr);
          pos_next    = CNT_W'(pos + 1'b1);
        end
      end
      ST_SHIFT: begin
        // move the entry just read one place towards the head
        we      = 1'b1;
        wr_addr = wr_ptr;
        wr_data = rd_data;
        if (last) begin
          cnt_next  = CNT_W'(cnt - 1'b1);
          tail_next = ptr_dec(tail);
        end else begin
          wr_ptr_next = rd_ptr;
          rd_addr     = ptr_inc(rd_ptr);
          rd_ptr_next = ptr_inc(rd_ptr);
          pos_next    = CNT_W'(pos + 1'b1);
        end
      end
      ST_RESP: res_valid = room;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
      head  <= '0;
      tail  <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      head  <= head_next;
      tail  <= tail_next;
    end
  end

  always_ff @(posedge clk) begin
    rd_ptr     <= rd_ptr_next;
    wr_ptr     <= wr_ptr_next;
    pos        <= pos_next;
    tag        <= tag_next;
    res_status <= res_status_next;
    res_data   <= res_data_next;
  end

  always_ff @(posedge clk) begin
    if (we) mem[wr_addr] <= wr_data;
    rd_data <= mem[rd_addr];
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= CNT_W'(DEPTH))
    else $error("entry count above depth");

  a_res_room: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> room)
    else $error("result issued with no room downstream");

  a_ptr_meet: assert property (@(posedge clk) disable iff (rst)
    (cnt == '0 || cnt == CNT_W'(DEPTH)) |-> (head == tail))
    else $error("head and tail apart on empty or full queue");

  a_busy_stall: assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE) |-> in_stall)
    else $error("transfer taken while sequencer busy");

  a_cnt_step: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SRCH || state == ST_SHIFT) |=>
      (cnt == $past(cnt) || cnt == CNT_W'($past(cnt) - 1'b1)))
    else $error("delete changed count by more than one");

endmodule

// ===== hdl/fifo_with_delete_by_value.sv =====
// Top level: request channel into the queue core, registered result channel.
//
//   channel  | valid     | stall      | payload
//   request  | in_valid  | in_stall   | req_type, value
//   result   | out_valid | out_stall  | status, out_value, length
//
// Enqueue, length and refused requests: result registered in the cycle after the transfer.
// Dequeue: head read, capture, issue. Delete: search, then compaction; the single
// read port of the tag store visits one entry a cycle.
// Synchronous reset empties the queue; the tag store itself is not cleared.
// A stalled result holds and blocks new requests until it is taken.
module fifo_with_delete_by_value (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [fwd_pkg::REQ_W-1:0]   req_type,
  input  logic [fwd_pkg::VAL_W-1:0]   value,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        status,
  output logic [fwd_pkg::VAL_W-1:0]   out_value,
  output logic [fwd_pkg::LEN_W-1:0]   length
);
  import fwd_pkg::*;

  logic     room;
  logic     res_valid;
  fwd_res_t res;

  assign room = !out_valid || !out_stall;

  fwd_core u_core (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .req_type  (req_type),
    .value     (value),
    .room      (room),
    .res_valid (res_valid),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      status    <= res.status;
      out_value <= res.value;
      length    <= res.length;
    end
  end

endmodule
